// File: sv/svpwm_pkg.sv
// Shared types and constants of the space-vector PWM duty calculator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package svpwm_pkg;

    localparam int unsigned DUTY_W = 16;
    localparam int unsigned EXC_W  = 13;
    localparam int unsigned MO_W   = 15;
    localparam int unsigned COS_W  = 17;
    localparam int unsigned X_W    = 33;
    localparam int unsigned MAG_W  = 32;
    localparam int unsigned QUO_W  = 18;

    localparam logic [15:0] BP0 = 16'd18919;
    localparam logic [15:0] BP1 = 16'd18973;
    localparam logic [15:0] BP2 = 16'd19785;
    localparam logic [15:0] BP3 = 16'd19848;
    localparam logic [14:0] YV0 = 15'd18919;
    localparam logic [14:0] YV1 = 15'd19005;
    localparam logic [14:0] YV2 = 15'd20935;
    localparam logic [14:0] YV3 = 15'd21846;

    localparam logic [63:0] Two32 = 64'h1_0000_0000;
    localparam logic [31:0] RCP1 = 32'((Two32 + 64'(BP1 - BP0) - 64'd1) / 64'(BP1 - BP0));
    localparam logic [31:0] RCP2 = 32'((Two32 + 64'(BP2 - BP1) - 64'd1) / 64'(BP2 - BP1));
    localparam logic [31:0] RCP3 = 32'((Two32 + 64'(BP3 - BP2) - 64'd1) / 64'(BP3 - BP2));

    localparam logic [15:0] DUTY_MIN_RST = 16'd6554;
    localparam logic [15:0] DUTY_MAX_RST = 16'd58982;
    localparam logic [1:0]  CFG_DUTY_MIN = 2'd0;
    localparam logic [1:0]  CFG_DUTY_MAX = 2'd1;

    localparam logic [31:0] NORM_MIN = 32'h4000_0000;

    typedef enum logic [4:0] {
        SEG_LIN = 5'b00001,
        SEG_1   = 5'b00010,
        SEG_2   = 5'b00100,
        SEG_3   = 5'b01000,
        SEG_SAT = 5'b10000
    } t_seg;

endpackage
`default_nettype wire

// File: sv/svpwm_ovm_map.sv
// Overmodulation map of the modulation index and the excess voltage.
// Three register stages; uses svpwm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svpwm_ovm_map (
    input  wire logic                       i_clk,
    input  wire logic                       i_ce,
    input  wire logic [15:0]                i_m,
    input  wire logic [11:0]                i_vdc,
    output logic [svpwm_pkg::MO_W-1:0]      o_mo,
    output logic [svpwm_pkg::EXC_W-1:0]     o_excess,
    output logic                            o_sat
);
    import svpwm_pkg::*;

    t_seg        n_seg;
    logic [15:0] n_base;
    logic [10:0] n_dy;
    logic [15:0] w_dm;

    t_seg        r1_seg;
    logic [15:0] r1_m;
    logic [20:0] r1_v;
    logic [27:0] r1_exc;
    t_seg        r2_seg;
    logic [15:0] r2_m;
    logic [14:0] r2_q;
    logic [EXC_W-1:0] r2_exc;

    logic [31:0] w_rcp;
    logic [14:0] w_ya;
    logic [52:0] w_prod;

    always_comb begin
        if (i_m < BP0) begin
            n_seg = SEG_LIN; n_base = BP0; n_dy = 11'd0;
        end else if (i_m < BP1) begin
            n_seg = SEG_1; n_base = BP0; n_dy = 11'(YV1 - YV0);
        end else if (i_m < BP2) begin
            n_seg = SEG_2; n_base = BP1; n_dy = 11'(YV2 - YV1);
        end else if (i_m < BP3) begin
            n_seg = SEG_3; n_base = BP2; n_dy = 11'(YV3 - YV2);
        end else begin
            n_seg = SEG_SAT; n_base = BP3; n_dy = 11'd0;
        end
        w_dm = i_m - n_base;
    end

    always_comb begin
        case (r1_seg)
            SEG_1:   w_rcp = RCP1;
            SEG_2:   w_rcp = RCP2;
            SEG_3:   w_rcp = RCP3;
            default: w_rcp = '0;
        endcase
        w_prod = 53'(r1_v) * 53'(w_rcp);
    end

    always_comb begin
        case (r2_seg)
            SEG_1:   w_ya = YV0;
            SEG_2:   w_ya = YV1;
            SEG_3:   w_ya = YV2;
            default: w_ya = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_seg <= n_seg;
            r1_m   <= i_m;
            r1_v   <= 21'(w_dm[9:0] * n_dy);
            r1_exc <= (n_seg == SEG_SAT) ? 28'(w_dm * 28'(i_vdc)) : '0;

            r2_seg <= r1_seg;
            r2_m   <= r1_m;
            r2_q   <= w_prod[46:32];
            r2_exc <= (r1_exc[27:15] > 13'h1FFF) ? 13'h1FFF : r1_exc[27:15];

            case (r2_seg)
                SEG_LIN: o_mo <= r2_m[14:0];
                SEG_SAT: o_mo <= YV3;
                default: o_mo <= w_ya + r2_q;
            endcase
            o_excess <= r2_exc;
            o_sat    <= (r2_seg == SEG_SAT);
        end
    end

endmodule
`default_nettype wire

// File: sv/svpwm_cos_lut.sv
// Cosine lookup of one phase: angle to table index, then a constant table.
// Three register stages; the table is built at elaboration. Uses svpwm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svpwm_cos_lut #(
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS      = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_ce,
    input  wire logic [PHASE_BITS-1:0]             i_ang,
    output logic signed [svpwm_pkg::COS_W-1:0]     o_cos
);
    import svpwm_pkg::*;

    localparam int IW = $clog2(COS_TABLE_DEPTH);
    localparam logic [63:0] QOne   = 64'h4000_0000;
    localparam logic [63:0] HalfPi = 64'd1686629713;

    typedef logic signed [COS_W-1:0] t_cos_tab [COS_TABLE_DEPTH];

    function automatic logic [63:0] f_qcos(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] s;
        x = r * HalfPi / COS_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t = QOne;
        for (int k = 0; k < 6; k++) begin
            p = (x2 * t) >> 30;
            case (k)
                0:       s = p / 132;
                1:       s = p / 90;
                2:       s = p / 56;
                3:       s = p / 30;
                4:       s = p / 12;
                default: s = p / 2;
            endcase
            t = (s > QOne) ? 64'd0 : QOne - s;
        end
        return t;
    endfunction

    function automatic t_cos_tab f_build();
        t_cos_tab    tab;
        logic [63:0] q4;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] c;
        logic [63:0] v;
        for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
            q4 = 64'(4 * i);
            quad = q4 / COS_TABLE_DEPTH;
            r = q4 - quad * COS_TABLE_DEPTH;
            if (quad == 0 || quad == 2) c = f_qcos(r);
            else c = f_qcos(64'(COS_TABLE_DEPTH) - r);
            v = (c + 64'h4000) >> 15;
            tab[i] = (quad == 1 || quad == 2) ? -COS_W'(v) : COS_W'(v);
        end
        return tab;
    endfunction

    localparam t_cos_tab CosTab = f_build();

    logic [IW-1:0]             r1_idx;
    logic signed [COS_W-1:0]   r2_cos;
    logic [PHASE_BITS+IW:0]    w_scaled;

    assign w_scaled = (PHASE_BITS + IW + 1)'(i_ang) *
                      (PHASE_BITS + IW + 1)'(COS_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_idx <= w_scaled[PHASE_BITS +: IW];
            r2_cos <= CosTab[r1_idx];
            o_cos  <= r2_cos;
        end
    end

endmodule
`default_nettype wire

// File: sv/svpwm_div.sv
// Pipelined restoring divider with rounding: round(mag * 2^15 / norm).
// Three quotient bits per register stage, six stages; uses svpwm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svpwm_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_ce,
    input  wire logic [svpwm_pkg::MAG_W-1:0]  i_mag,
    input  wire logic [svpwm_pkg::MAG_W-1:0]  i_norm,
    output logic [svpwm_pkg::QUO_W-1:0]       o_quo
);
    import svpwm_pkg::*;

    localparam int BitsPerStage = 3;
    localparam int NStage       = QUO_W / BitsPerStage;
    localparam int RemW         = MAG_W + 1;

    logic [47:0] w_dvd;
    logic [RemW-1:0]  r_rem  [NStage];
    logic [QUO_W-1:0] r_low  [NStage];
    logic [MAG_W-1:0] r_norm [NStage];

    assign w_dvd = {1'b0, i_mag, 15'd0} + 48'(i_norm >> 1);

    for (genvar g = 0; g < NStage; g++) begin : g_stage
        logic [RemW-1:0]  w_rem_in;
        logic [QUO_W-1:0] w_low_in;
        logic [MAG_W-1:0] w_norm_in;
        logic [RemW-1:0]  w_rem;
        logic [QUO_W-1:0] w_low;

        if (g == 0) begin : g_first
            assign w_rem_in  = RemW'(w_dvd[47:QUO_W]);
            assign w_low_in  = w_dvd[QUO_W-1:0];
            assign w_norm_in = i_norm;
        end else begin : g_next
            assign w_rem_in  = r_rem[g-1];
            assign w_low_in  = r_low[g-1];
            assign w_norm_in = r_norm[g-1];
        end

        always_comb begin
            w_rem = w_rem_in;
            w_low = w_low_in;
            for (int k = 0; k < BitsPerStage; k++) begin
                w_rem = {w_rem[RemW-2:0], w_low[QUO_W-1]};
                w_low = {w_low[QUO_W-2:0], 1'b0};
                if (w_rem >= RemW'(w_norm_in)) begin
                    w_rem = w_rem - RemW'(w_norm_in);
                    w_low[0] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[g]  <= w_rem;
                r_low[g]  <= w_low;
                r_norm[g] <= w_norm_in;
            end
        end
    end

    assign o_quo = r_low[NStage-1];

endmodule
`default_nettype wire

// File: sv/svpwm_overmod_duty_calc.sv
// Top level of the space-vector PWM duty calculator with overmodulation.
// Uses svpwm_pkg, svpwm_ovm_map, svpwm_cos_lut and svpwm_div.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one item per clock while the output is not stalled, and
// returns one result item for each. Its registered steps, in order, are the
// overmodulation map and the cosine tables, the phase products, min-max
// injection, the rounding divider and the clamp into the output register.
// The whole pipeline advances whenever the output register is free or being
// read, so a stall on the output holds every stage in place.
module svpwm_overmod_duty_calc #(
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS      = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // modulation_index[15:0], phase_angle[31:16], dc_link_voltage[43:32], zero pad
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // duty_a[15:0], duty_b[31:16], duty_c[47:32], overmod_excess[60:48],
    // overmod_saturated[61], zero pad
    output logic [63:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import svpwm_pkg::*;

    localparam int Latency = 11;
    localparam longint Turn     = longint'(1) << PHASE_BITS;
    localparam longint Third    = (Turn + 1) / 3;
    localparam longint TwoThird = (2 * Turn + 1) / 3;

    logic             w_ce;
    logic [Latency-1:0] r_vld;
    logic [15:0]      r_duty_min;
    logic [15:0]      r_duty_max;

    logic [PHASE_BITS-1:0] w_ang [3];
    logic signed [COS_W-1:0] w_cos [3];
    logic [MO_W-1:0]  w_mo;
    logic [EXC_W-1:0] w_exc;
    logic             w_sat;

    logic signed [X_W-1:0] r_x [3];
    logic signed [X_W-1:0] w_mn;
    logic signed [X_W-1:0] w_mx;
    logic signed [X_W:0]   w_span;
    logic [MAG_W-1:0]      r_mag [3];
    logic [2:0]            r_neg;
    logic [MAG_W-1:0]      r_norm;
    logic [QUO_W-1:0]      w_quo [3];

    logic [EXC_W-1:0] r_exc [2];
    logic [1:0]       r_sat;
    logic [EXC_W-1:0] r_dexc [6];
    logic [5:0]       r_dsat;
    logic [2:0]       r_dneg [6];

    logic [DUTY_W-1:0] r_duty [3];
    logic [EXC_W-1:0]  r_oexc;
    logic              r_osat;
    logic              r_ovld;

    assign w_ce          = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_ce;
    assign m_axis_tvalid = r_ovld;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = {2'b00, r_osat, r_oexc, r_duty[2], r_duty[1], r_duty[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_min <= DUTY_MIN_RST;
            r_duty_max <= DUTY_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DUTY_MIN: r_duty_min <= i_cfg_data;
                CFG_DUTY_MAX: r_duty_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_ce) begin
            r_vld  <= {r_vld[Latency-2:0], s_axis_tvalid};
            r_ovld <= r_vld[Latency-1];
        end
    end

    assign w_ang[0] = PHASE_BITS'(s_axis_tdata[31:16]);
    assign w_ang[1] = w_ang[0] + PHASE_BITS'(Turn - Third);
    assign w_ang[2] = w_ang[0] + PHASE_BITS'(Turn - TwoThird);

    svpwm_ovm_map u_map (
        .i_clk    (i_clk),
        .i_ce     (w_ce),
        .i_m      (s_axis_tdata[15:0]),
        .i_vdc    (s_axis_tdata[43:32]),
        .o_mo     (w_mo),
        .o_excess (w_exc),
        .o_sat    (w_sat)
    );

    for (genvar p = 0; p < 3; p++) begin : g_phase
        svpwm_cos_lut #(
            .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
            .PHASE_BITS      (PHASE_BITS)
        ) u_cos (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_ang (w_ang[p]),
            .o_cos (w_cos[p])
        );

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_x[p] <= X_W'($signed({1'b0, w_mo}) * w_cos[p]);
            end
        end

        svpwm_div u_div (
            .i_clk  (i_clk),
            .i_ce   (w_ce),
            .i_mag  (r_mag[p]),
            .i_norm (r_norm),
            .o_quo  (w_quo[p])
        );
    end

    always_comb begin
        w_mn = r_x[0];
        w_mx = r_x[0];
        for (int k = 1; k < 3; k++) begin
            if (r_x[k] < w_mn) w_mn = r_x[k];
            if (r_x[k] > w_mx) w_mx = r_x[k];
        end
        w_span = (X_W + 1)'(w_mx) - (X_W + 1)'(w_mn);
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [X_W+1:0] v_e;
                v_e = (X_W + 2)'(r_x[k]) * 2 - (X_W + 2)'(w_mx) - (X_W + 2)'(w_mn);
                r_neg[k] <= v_e[X_W+1];
                r_mag[k] <= v_e[X_W+1] ? MAG_W'(-v_e) : MAG_W'(v_e);
            end
            r_norm <= (w_span < (X_W + 1)'(NORM_MIN)) ? NORM_MIN : MAG_W'(w_span);

            r_exc[0] <= w_exc;
            r_sat[0] <= w_sat;
            r_exc[1] <= r_exc[0];
            r_sat[1] <= r_sat[0];
            for (int k = 0; k < 6; k++) begin
                r_dexc[k] <= (k == 0) ? r_exc[1] : r_dexc[(k == 0) ? 0 : k - 1];
                r_dsat[k] <= (k == 0) ? r_sat[1] : r_dsat[(k == 0) ? 0 : k - 1];
                r_dneg[k] <= (k == 0) ? r_neg    : r_dneg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [18:0] v_d;
                v_d = r_dneg[5][k] ? 19'sd32768 - 19'(w_quo[k])
                                   : 19'sd32768 + 19'(w_quo[k]);
                if (v_d > $signed({3'b000, r_duty_max})) v_d = $signed({3'b000, r_duty_max});
                if (v_d < $signed({3'b000, r_duty_min})) v_d = $signed({3'b000, r_duty_min});
                r_duty[k] <= v_d[15:0];
            end
            r_oexc <= r_dexc[5];
            r_osat <= r_dsat[5];
        end
    end

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for svpwm_overmod_duty_calc: directed and random items
// are checked against a behavioral predictor held in a scoreboard class.
// Depends on svpwm_pkg and the RTL of the block.
`timescale 1ns / 1ps

class duty_scoreboard;
    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [12:0] excess;
        logic        saturated;
    } duty_item_t;

    duty_item_t  pending[$];
    int          errors;
    int signed   cos_lut[1024];
    logic [15:0] lo_clamp;
    logic [15:0] hi_clamp;

    function new();
        longint unsigned r;
        longint unsigned c;
        int signed v;
        errors = 0;
        lo_clamp = svpwm_pkg::DUTY_MIN_RST;
        hi_clamp = svpwm_pkg::DUTY_MAX_RST;
        for (int i = 0; i < 1024; i++) begin
            r = (4 * i) % 1024;
            if ((4 * i) / 1024 == 0 || (4 * i) / 1024 == 2) c = quarter_wave(r);
            else c = quarter_wave(1024 - r);
            v = int'((c + (64'd1 << 14)) >> 15);
            cos_lut[i] = ((4 * i) / 1024 == 1 || (4 * i) / 1024 == 2) ? -v : v;
        end
    endfunction

    function longint unsigned quarter_wave(longint unsigned r);
        longint unsigned divs[6];
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        divs = '{132, 90, 56, 30, 12, 2};
        x = r * 64'd1686629713 / 1024;
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int k = 0; k < 6; k++) begin
            s = ((x2 * t) >> 30) / divs[k];
            t = (s > (64'd1 << 30)) ? 0 : (64'd1 << 30) - s;
        end
        return t;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] val);
        if (idx == svpwm_pkg::CFG_DUTY_MIN) lo_clamp = val;
        else if (idx == svpwm_pkg::CFG_DUTY_MAX) hi_clamp = val;
    endfunction

    function longint lut_at(longint unsigned ang);
        return cos_lut[((ang & 64'hFFFF) * 1024) >> 16];
    endfunction

    function logic [15:0] injected_duty(longint x, longint mx, longint mn, longint nrm);
        longint num;
        longint mag;
        longint q;
        longint d;
        num = (2 * x - mx - mn) * 32768;
        mag = num < 0 ? -num : num;
        q = (mag + nrm / 2) / nrm;
        d = 32768 + (num < 0 ? -q : q);
        if (d > hi_clamp) d = hi_clamp;
        if (d < lo_clamp) d = lo_clamp;
        return d[15:0];
    endfunction

    function void note_input(logic [15:0] m_in, logic [15:0] ang, logic [11:0] vdc);
        duty_item_t e;
        longint m;
        longint mo;
        longint unsigned exc;
        longint a;
        longint b;
        longint c;
        longint mn;
        longint mx;
        longint nrm;
        m = m_in;
        exc = 0;
        e.saturated = 0;
        if (m < 18919) mo = m;
        else if (m < 18973) mo = 18919 + (19005 - 18919) * (m - 18919) / (18973 - 18919);
        else if (m < 19785) mo = 19005 + (20935 - 19005) * (m - 18973) / (19785 - 18973);
        else if (m < 19848) mo = 20935 + (21846 - 20935) * (m - 19785) / (19848 - 19785);
        else begin
            mo = 21846;
            e.saturated = 1;
            exc = (longint'(m - 19848) * vdc) >> 15;
            if (exc > 8191) exc = 8191;
        end
        a = mo * lut_at(ang);
        b = mo * lut_at(ang + 65536 - 21845);
        c = mo * lut_at(ang + 65536 - 43691);
        mn = a < b ? a : b;
        mn = mn < c ? mn : c;
        mx = a > b ? a : b;
        mx = mx > c ? mx : c;
        nrm = (mx - mn) > (64'sd1 << 30) ? mx - mn : (64'sd1 << 30);
        e.duty_a = injected_duty(a, mx, mn, nrm);
        e.duty_b = injected_duty(b, mx, mn, nrm);
        e.duty_c = injected_duty(c, mx, mn, nrm);
        e.excess = exc[12:0];
        pending.push_back(e);
    endfunction

    function void check_result(logic [63:0] data);
        duty_item_t e;
        if (pending.size() == 0) begin
            report("result item with nothing expected", 0, 0);
            return;
        end
        e = pending.pop_front();
        if (data[15:0] !== e.duty_a) report("duty_a", data[15:0], e.duty_a);
        if (data[31:16] !== e.duty_b) report("duty_b", data[31:16], e.duty_b);
        if (data[47:32] !== e.duty_c) report("duty_c", data[47:32], e.duty_c);
        if (data[60:48] !== e.excess) report("overmod_excess", data[60:48], e.excess);
        if (data[61] !== e.saturated) report("overmod_saturated", data[61], e.saturated);
    endfunction

    function void report(string what, longint got, longint want);
        errors++;
        if (errors <= 50) $display("mismatch %s: got %0d expected %0d", what, got, want);
    endfunction
endclass

module tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    bit          stall_mode;

    duty_scoreboard duty_sb;

    svpwm_overmod_duty_calc u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("svpwm_overmod_duty_calc regression: fail");
        $finish;
    end

    function int gap_length();
        if (!stall_mode) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) duty_sb.check_result(m_axis_tdata);
    end

    initial begin
        int g;
        m_axis_tready = 0;
        forever begin
            g = gap_length();
            if (g > 0) begin
                m_axis_tready <= 0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
        end
    end

    task automatic send_item(logic [15:0] m, logic [15:0] ang, logic [11:0] vdc);
        int g;
        g = gap_length();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {4'd0, vdc, ang, m};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        duty_sb.note_input(m, ang, vdc);
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        duty_sb.set_register(idx, val);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (duty_sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function logic [15:0] random_index();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(18900, 19900));
            1: return 16'($urandom_range(19840, 19860));
            2: return 16'($urandom_range(19780, 19790));
            3: return 16'($urandom_range(18915, 18980));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        logic [15:0] mins[4];
        logic [15:0] maxs[4];
        duty_sb = new();
        stall_mode = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_item(16'd0, 16'd0, 12'd0);
        send_item(16'hFFFF, 16'hFFFF, 12'hFFF);
        send_item(16'd18918, 16'd16384, 12'd100);
        send_item(16'd18919, 16'd21845, 12'd100);
        send_item(16'd18973, 16'd32768, 12'd500);
        send_item(16'd19785, 16'd43690, 12'd500);
        send_item(16'd19847, 16'd49152, 12'd4095);
        send_item(16'd19848, 16'd1000, 12'd4095);
        send_item(16'd40000, 16'd5461, 12'd4095);
        send_item(16'd32768, 16'd60000, 12'd2048);
        send_item(16'hAAAA, 16'h5555, 12'hAAA);
        send_item(16'h5555, 16'hAAAA, 12'h555);
        drain();
        write_register(svpwm_pkg::CFG_DUTY_MIN, 16'd40000);
        write_register(svpwm_pkg::CFG_DUTY_MAX, 16'd20000);
        send_item(16'd10000, 16'd3000, 12'd10);
        send_item(16'd30000, 16'd40000, 12'd3000);
        drain();
        write_register(2'd2, 16'd1234);
        write_register(2'd3, 16'd4321);
        send_item(16'd20000, 16'd12000, 12'd800);
        drain();

        mins = '{16'd0, 16'd0, 16'd6554, 16'hFFFF};
        maxs = '{16'hFFFF, 16'd0, 16'd58982, 16'hFFFF};
        for (int p = 0; p < 6; p++) begin
            if (p < 4) begin
                write_register(svpwm_pkg::CFG_DUTY_MIN, mins[p]);
                write_register(svpwm_pkg::CFG_DUTY_MAX, maxs[p]);
            end else begin
                write_register(svpwm_pkg::CFG_DUTY_MIN, 16'($urandom_range(0, 30000)));
                write_register(svpwm_pkg::CFG_DUTY_MAX, 16'($urandom_range(30000, 65535)));
            end
            stall_mode = (p % 3) != 0;
            for (int n = 0; n < 155; n++)
                send_item(random_index(), 16'($urandom_range(0, 65535)),
                          12'($urandom_range(0, 4095)));
            drain();
        end

        if (duty_sb.errors == 0) begin
            $display("svpwm_overmod_duty_calc regression: pass");
        end else begin
            $display("svpwm_overmod_duty_calc regression: fail");
        end
        $finish;
    end
endmodule
